FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl; empty bodies when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/woda_pkg.sv
package woda_pkg;

  localparam int MaxPointsDef = 512;
  localparam int WsumW        = 64;
  localparam int WgtW         = 48;
  localparam int DivNumW      = 80;
  localparam int DivDenW      = 48;
  localparam int DivCntW      = $clog2(DivNumW + 1);

  localparam logic [31:0] Ln2Q32   = 32'd2977044472;
  localparam logic [31:0] Log2eQ30 = 32'd1549082005;
  localparam logic [31:0] Sat32    = 32'hFFFF_FFFF;
  localparam logic [15:0] DiffReset = 16'd27197;

  // averaging modes
  localparam logic [2:0] ModeLinear = 3'd0;
  localparam logic [2:0] ModeTrans  = 3'd1;
  localparam logic [2:0] ModeTrans2 = 3'd2;
  localparam logic [2:0] ModeSquare = 3'd3;
  localparam logic [2:0] ModeLog    = 3'd4;

  // register indexes
  localparam logic RegMode = 1'b0;
  localparam logic RegDiff = 1'b1;

  typedef struct packed {
    logic               go;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quo;
  } div_rsp_t;

  typedef logic [30:1][31:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = val;
    res = '0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bt != 0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // successive square roots of two in q2.30
  function automatic root_tab_t build_roots();
    root_tab_t   tab;
    logic [63:0] t;
    t = 64'd1 << 31;
    for (int i = 1; i <= 30; i++) begin
      t      = isqrt64(t << 30);
      tab[i] = t[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ExpRoot = build_roots();

  function automatic logic [4:0] msb_index(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int k = 0; k < 32; k++) begin
      if (x[k]) p = 5'(k);
    end
    return p;
  endfunction

endpackage

FILE: rtl/weighted_optical_depth_average_top.sv
// weighted optical depth average
// input stream: one item per spectral point; s_tdata carries metric and planck
// weight (both unsigned q16.16), s_tlast marks the last point of a row.
// output stream: one item per row; m_tdata is the averaged optical depth
// (unsigned q16.16, saturated), m_tuser is the zero weight flag.
// config port: cfg_we / cfg_index / cfg_data write averaging mode (index 0)
// and diffusivity in q2.14 (index 1); write only while the block is idle.
// one point is worked at a time on a shared 32x32 multiplier and an 80-step
// restoring divider. a point within MAX_POINTS and with a nonzero metric also
// runs the 24-step squaring log chain on the multiplier. a row end adds the
// mean divide (linear), a divide then a square (square), divide then log then
// divide (transmission) or divide, 30-step exp, divide (log mode).
// s_tready is high only while the sequencer waits for a point.
// the result sits in an output register, so a new row can start while the
// previous result waits; a stalled receiver only holds the block at a row end.
// reset clears the row sums, sets linear mode and the default diffusivity.
`include "assert_macros.svh"
module weighted_optical_depth_average_top #(
  parameter int MAX_POINTS = woda_pkg::MaxPointsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // metric_value [31:0], planck_weight [63:32]
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // optical_depth [31:0]
  output logic        m_tuser,   // zero_weight
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import woda_pkg::*;

  localparam int PcW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MAC, S_LN_INIT, S_LN_SQ, S_LN_SC, S_LN_W, S_END, S_MEAN_DIV,
    S_TR_DIV, S_SQ_MUL, S_LG_DIV, S_EXP_MUL, S_EXP_IT, S_EXP_SH, S_SC_MUL,
    S_SC_DIV, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [2:0]  mode;
  logic [15:0] diff;

  // row sums
  logic [WsumW-1:0]        weighted_sum;
  logic [WgtW-1:0]         weight_sum;
  logic signed [63:0]      weighted_log_sum;
  logic [WgtW-1:0]         nonzero_weight_sum;
  logic [PcW-1:0]          point_count;
  logic [PcW-1:0]          nonzero_count;

  // current point
  logic [31:0] m_reg;
  logic [31:0] w_reg;
  logic        last_reg;
  logic        acc_reg;

  // log unit working registers
  logic [31:0] ln_x;
  logic [4:0]  ln_pos;
  logic [31:0] ln_v;
  logic [23:0] ln_frac;
  logic [31:0] ln_mag;
  logic        ln_neg;
  logic        ln_ctx;   // high: log of (1 - t) for transmission
  logic [4:0]  cnt;

  // row end working registers
  logic [31:0]        mean;
  logic [31:0]        res;
  logic               zw;
  logic               y_neg;
  logic signed [7:0]  exp_s;
  logic [29:0]        exp_f;
  logic [31:0]        exp_r;
  logic [31:0]        e_val;

  logic        mul_wait;
  logic        mul_state;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // combinational helpers
  logic [4:0]         norm_pos;
  logic [31:0]        norm_v;
  logic [31:0]        sq;
  logic [5:0]         ln_ex;
  logic signed [29:0] ln_l2;
  logic [29:0]        ln_l2_mag;
  logic [31:0]        ln_round;
  logic [63:0]        wls_mag;
  logic signed [63:0] exp_prod;
  logic signed [63:0] exp_z;
  logic [63:0]        exp_v;
  logic [7:0]         exp_rsh;
  logic [31:0]        e_next;
  logic [31:0]        div_sat;
  logic [15:0]        tclamp;
  logic [16:0]        d_base;
  logic [17:0]        d_eff;
  logic               acc_next;

  woda_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  woda_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready = (state == S_IDLE);
  assign acc_next = point_count < PcW'(MAX_POINTS);

  always_comb begin
    mul_state = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_MAC:     begin mul_state = 1'b1; mul_a = m_reg;   mul_b = w_reg;        end
      S_LN_SQ:   begin mul_state = 1'b1; mul_a = ln_v;    mul_b = ln_v;         end
      S_LN_SC:   begin mul_state = 1'b1; mul_a = 32'(ln_l2_mag); mul_b = Ln2Q32; end
      S_LN_W:    begin mul_state = 1'b1; mul_a = ln_mag;  mul_b = w_reg;        end
      S_SQ_MUL:  begin mul_state = 1'b1; mul_a = mean;    mul_b = mean;         end
      S_EXP_MUL: begin mul_state = 1'b1; mul_a = div_sat; mul_b = Log2eQ30;     end
      S_EXP_IT:  begin mul_state = 1'b1; mul_a = exp_r;   mul_b = ExpRoot[cnt]; end
      S_SC_MUL:  begin mul_state = 1'b1; mul_a = e_val;   mul_b = 32'(nonzero_count); end
      default:   begin mul_state = 1'b0; end
    endcase
  end

  always_comb begin
    // normalise to q1.30
    norm_pos = msb_index(ln_x);
    if (norm_pos >= 5'd30) norm_v = ln_x >> (norm_pos - 5'd30);
    else norm_v = ln_x << (5'd30 - norm_pos);
    sq = mul_p[61:30];
    // log2 in q.24, then scaled by ln2 with rounding on the magnitude
    ln_ex     = 6'(ln_pos) - 6'd16;
    ln_l2     = {ln_ex, ln_frac};
    ln_l2_mag = ln_l2[29] ? 30'(-ln_l2) : 30'(ln_l2);
    ln_round  = 32'((mul_p + 64'h80_0000_0000) >> 40);
    wls_mag   = weighted_log_sum[63] ? 64'(-weighted_log_sum) : 64'(weighted_log_sum);
    // exp: floor to q.30 of y*log2(e)
    exp_prod = y_neg ? -$signed(mul_p) : $signed(mul_p);
    exp_z    = exp_prod >>> 16;
    exp_v    = {32'b0, exp_r} << exp_s[5:0];
    exp_rsh  = 8'(-exp_s);
    if (!exp_s[7]) begin
      e_next = (exp_s > 8'sd33 || exp_v[63:32] != '0) ? Sat32 : exp_v[31:0];
    end else begin
      e_next = (exp_rsh >= 8'd32) ? '0 : (exp_r >> exp_rsh[4:0]);
    end
    div_sat = (div_rsp.quo[DivNumW-1:32] != '0) ? Sat32 : div_rsp.quo[31:0];
    tclamp  = (div_sat > 32'd65535) ? 16'hFFFF : div_sat[15:0];
    d_base  = (diff == '0) ? 17'd1 : {1'b0, diff};
    d_eff   = (mode == ModeTrans2) ? {d_base, 1'b0} : {1'b0, d_base};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      mode               <= ModeLinear;
      diff               <= DiffReset;
      weighted_sum       <= '0;
      weight_sum         <= '0;
      weighted_log_sum   <= '0;
      nonzero_weight_sum <= '0;
      point_count        <= '0;
      nonzero_count      <= '0;
      mul_wait           <= 1'b0;
      m_tvalid           <= 1'b0;
      div_req.go         <= 1'b0;
    end else begin
      div_req.go <= 1'b0;
      if (mul_state) mul_wait <= !mul_wait;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          RegMode: mode <= cfg_data[2:0];
          RegDiff: diff <= cfg_data;
          default: mode <= mode;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            m_reg    <= s_tdata[31:0];
            w_reg    <= s_tdata[63:32];
            last_reg <= s_tlast;
            acc_reg  <= acc_next;
            state    <= S_MAC;
          end
        end

        S_MAC: begin
          if (mul_wait) begin
            if (acc_reg) begin
              weighted_sum <= weighted_sum + 64'(mul_p[63:16]);
              weight_sum   <= weight_sum + WgtW'(w_reg);
              point_count  <= point_count + 1'b1;
            end
            if (acc_reg && m_reg != '0) begin
              ln_x   <= m_reg;
              ln_ctx <= 1'b0;
              state  <= S_LN_INIT;
            end else begin
              state <= last_reg ? S_END : S_IDLE;
            end
          end
        end

        S_LN_INIT: begin
          ln_pos  <= norm_pos;
          ln_v    <= norm_v;
          ln_frac <= '0;
          cnt     <= 5'd23;
          state   <= S_LN_SQ;
        end

        S_LN_SQ: begin
          if (mul_wait) begin
            if (sq[31]) begin
              ln_v         <= sq >> 1;
              ln_frac[cnt] <= 1'b1;
            end else begin
              ln_v <= sq;
            end
            if (cnt == '0) state <= S_LN_SC;
            else cnt <= cnt - 1'b1;
          end
        end

        S_LN_SC: begin
          if (mul_wait) begin
            ln_mag <= ln_round;
            ln_neg <= ln_l2[29];
            if (ln_ctx) begin
              div_req.go  <= 1'b1;
              div_req.num <= DivNumW'({ln_round, 14'b0});
              div_req.den <= DivDenW'(d_eff);
              state       <= S_TR_DIV;
            end else begin
              state <= S_LN_W;
            end
          end
        end

        S_LN_W: begin
          if (mul_wait) begin
            weighted_log_sum   <= ln_neg ? weighted_log_sum - $signed(mul_p)
                                         : weighted_log_sum + $signed(mul_p);
            nonzero_weight_sum <= nonzero_weight_sum + WgtW'(w_reg);
            nonzero_count      <= nonzero_count + 1'b1;
            state              <= last_reg ? S_END : S_IDLE;
          end
        end

        S_END: begin
          res <= '0;
          zw  <= 1'b0;
          if (mode == ModeLog) begin
            if (nonzero_count == '0) begin
              state <= S_OUT;
            end else if (nonzero_weight_sum == '0) begin
              zw    <= 1'b1;
              state <= S_OUT;
            end else begin
              div_req.go  <= 1'b1;
              div_req.num <= DivNumW'(wls_mag);
              div_req.den <= nonzero_weight_sum;
              y_neg       <= weighted_log_sum[63];
              state       <= S_LG_DIV;
            end
          end else if (weight_sum == '0) begin
            zw    <= 1'b1;
            state <= S_OUT;
          end else begin
            div_req.go  <= 1'b1;
            div_req.num <= {weighted_sum, 16'b0};
            div_req.den <= weight_sum;
            state       <= S_MEAN_DIV;
          end
        end

        S_MEAN_DIV: begin
          if (div_rsp.done) begin
            mean <= div_sat;
            if (mode == ModeTrans || mode == ModeTrans2) begin
              ln_x   <= 32'd65536 - {16'b0, tclamp};
              ln_ctx <= 1'b1;
              state  <= S_LN_INIT;
            end else if (mode == ModeSquare) begin
              state <= S_SQ_MUL;
            end else begin
              res   <= div_sat;
              state <= S_OUT;
            end
          end
        end

        S_TR_DIV: begin
          if (div_rsp.done) begin
            res   <= div_sat;
            state <= S_OUT;
          end
        end

        S_SQ_MUL: begin
          if (mul_wait) begin
            res   <= (mul_p[63:48] != '0) ? Sat32 : mul_p[47:16];
            state <= S_OUT;
          end
        end

        S_LG_DIV: begin
          if (div_rsp.done) state <= S_EXP_MUL;
        end

        // divider output holds the mean log magnitude until the next start
        S_EXP_MUL: begin
          if (mul_wait) begin
            exp_s <= exp_z[37:30] - 8'sd14;
            exp_f <= exp_z[29:0];
            exp_r <= 32'd1 << 30;
            cnt   <= 5'd1;
            state <= S_EXP_IT;
          end
        end

        S_EXP_IT: begin
          if (mul_wait) begin
            if (exp_f[29]) exp_r <= mul_p[61:30];
            exp_f <= exp_f << 1;
            if (cnt == 5'd30) state <= S_EXP_SH;
            else cnt <= cnt + 1'b1;
          end
        end

        S_EXP_SH: begin
          e_val <= e_next;
          state <= S_SC_MUL;
        end

        S_SC_MUL: begin
          if (mul_wait) begin
            div_req.go  <= 1'b1;
            div_req.num <= DivNumW'(mul_p);
            div_req.den <= DivDenW'(point_count);
            state       <= S_SC_DIV;
          end
        end

        S_SC_DIV: begin
          if (div_rsp.done) begin
            res   <= div_rsp.quo[31:0];
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid           <= 1'b1;
            m_tdata            <= res;
            m_tuser            <= zw;
            weighted_sum       <= '0;
            weight_sum         <= '0;
            weighted_log_sum   <= '0;
            nonzero_weight_sum <= '0;
            point_count        <= '0;
            nonzero_count      <= '0;
            state              <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_pc_bound, clk, rst, point_count <= PcW'(MAX_POINTS))
  `ASSERT_ALWAYS(a_nz_bound, clk, rst, nonzero_count <= point_count)
  `ASSERT_IMPLY(a_out_from_seq, clk, rst, $rose(m_tvalid), $past(state == S_OUT))
  `ASSERT_IMPLY(a_zw_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)
endmodule

FILE: rtl/woda_mul.sv
module woda_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  // registered 32x32 product, shared by every multiply step
  always_ff @(posedge clk) begin
    p <= {32'b0, a} * {32'b0, b};
  end
endmodule

FILE: rtl/woda_div.sv
`include "assert_macros.svh"
module woda_div (
  input  logic                clk,
  input  logic                rst,
  input  woda_pkg::div_req_t  req,
  output woda_pkg::div_rsp_t  rsp
);
  import woda_pkg::*;

  logic [DivNumW-1:0] quo;
  logic [DivDenW:0]   rem;
  logic [DivDenW-1:0] den;
  logic [DivCntW-1:0] cnt;
  logic               busy;
  logic               done;
  logic [DivDenW:0]   rem_sh;
  logic [DivDenW:0]   rem_sub;
  logic               take;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh  = {rem[DivDenW-1:0], quo[DivNumW-1]};
    take    = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= DivCntW'(DivNumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (req.go) begin
      quo <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      rem <= take ? rem_sub : rem_sh;
      quo <= {quo[DivNumW-2:0], take};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

  `ASSERT_IMPLY(a_go_when_idle, clk, rst, req.go, !busy)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ASSERT_IMPLY(a_done_ends_busy, clk, rst, done, $past(busy) && !busy)
endmodule

FILE: tb/weighted_optical_depth_average_top_test.sv
`default_nettype none

module weighted_optical_depth_average_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import woda_pkg::*;

  localparam int RowCap = 512;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // metric_value [31:0], planck_weight [63:32]
  logic        s_tlast;   // last_point
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // optical_depth [31:0]
  logic        m_tuser;   // zero_weight
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  weighted_optical_depth_average_top dut (.*);

  // one averaged row result
  typedef struct {
    logic [31:0] depth;
    logic        zero_wt;
  } row_result_t;

  // one directed row of the stimulus table: a register write or a point
  typedef struct {
    bit          wr;
    logic        wr_idx;
    logic [15:0] wr_val;
    logic [31:0] metric;
    logic [31:0] weight;
    bit          last;
    bit          typed;     // expected result given in the table
    logic [31:0] depth;
    logic        zero_wt;
  } point_row_t;

  row_result_t depth_q[$];
  int          errors;
  bit          quiet;       // no idling in the closing stretch
  bit          hold_req;    // receiver long hold-off

  // predictor copy of the registers and row sums
  logic [2:0]        mode_r;
  logic [15:0]       diff_r;
  longint unsigned   wsum;
  longint unsigned   wtsum;
  longint            logsum;
  longint unsigned   nzwsum;
  int                npts;
  int                nnz;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("weighted_optical_depth_average_top: mismatch");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned val);
    longint unsigned v, res, b;
    v   = val;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // natural log of a nonzero unsigned q16.16, signed q16.16
  function automatic longint nat_log(input logic [31:0] x);
    int              p;
    longint unsigned v, frac, mag;
    longint          l2;
    p    = 0;
    frac = 0;
    for (int k = 0; k < 32; k++) if (x[k]) p = k;
    v = (p >= 30) ? (64'(x) >> (p - 30)) : (64'(x) << (30 - p));
    for (int i = 23; i >= 0; i--) begin
      v = (v * v) >> 30;
      if (v >= (64'd1 << 31)) begin
        v    = v >> 1;
        frac = frac | (64'd1 << i);
      end
    end
    l2  = longint'(p - 16) * (longint'(1) << 24) + longint'(frac);
    mag = (l2 < 0) ? longint'(-l2) : l2;
    mag = (mag * 64'(Ln2Q32) + (64'd1 << 39)) >> 40;
    return (l2 < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // exponential of signed q16.16, unsigned q16.16 saturated
  function automatic longint unsigned nat_exp(input longint y);
    longint          prod, z30, n;
    longint unsigned zz, f, r, t, v;
    int              s;
    prod = y * longint'(Log2eQ30);
    if (prod >= 0) z30 = longint'(longint'(unsigned'(prod)) >>> 16);
    else z30 = -longint'((longint'(-prod) + 65535) >> 16);
    zz = longint'(z30 + (longint'(128) << 30));
    n  = longint'(zz >> 30) - 128;
    f  = zz & ((64'd1 << 30) - 1);
    r  = 64'd1 << 30;
    t  = 64'd1 << 31;
    for (int i = 1; i <= 30; i++) begin
      t = int_sqrt(t << 30);
      if ((f >> (30 - i)) & 1) r = (r * t) >> 30;
    end
    s = int'(n - 14);
    if (s >= 0) begin
      if (s > 33) return 64'(Sat32);
      v = r << s;
      return (v > 64'(Sat32)) ? 64'(Sat32) : v;
    end
    if (-s >= 63) return 0;
    return r >> (-s);
  endfunction

  // floor(num * 2^16 / den), saturated
  function automatic longint unsigned mean_q16(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned q, r, frac;
    q    = num / den;
    r    = num % den;
    frac = 0;
    if (q >= 65536) return 64'(Sat32);
    for (int i = 0; i < 16; i++) begin
      r    = r << 1;
      frac = frac << 1;
      if (r >= den) begin
        r    = r - den;
        frac = frac | 1;
      end
    end
    return (q << 16) | frac;
  endfunction

  // accumulate one point; at the row end work out the averaged depth
  function automatic bit average_point(input logic [31:0] metric, input logic [31:0] weight,
                                       input bit last, output row_result_t res);
    longint unsigned m, w, mean, tc, l, d, o, mag, q, e;
    longint          ym;
    m = 64'(metric);
    w = 64'(weight);
    o = 0;
    res.zero_wt = 1'b0;
    if (npts < RowCap) begin
      wsum  += (m * w) >> 16;
      wtsum += w;
      npts++;
      if (m != 0) begin
        logsum += nat_log(metric) * longint'(w);
        nzwsum += w;
        nnz++;
      end
    end
    if (!last) return 1'b0;
    if (mode_r == ModeLog) begin
      if (nnz == 0) begin
        o = 0;
      end else if (nzwsum == 0) begin
        res.zero_wt = 1'b1;
      end else begin
        mag = (logsum < 0) ? longint'(-logsum) : longint'(logsum);
        q   = mag / nzwsum;
        ym  = (logsum < 0) ? -longint'(q) : longint'(q);
        e   = nat_exp(ym);
        o   = (e * 64'(nnz)) / 64'(npts);
      end
    end else if (wtsum == 0) begin
      res.zero_wt = 1'b1;
    end else begin
      mean = mean_q16(wsum, wtsum);
      if (mode_r == ModeTrans || mode_r == ModeTrans2) begin
        tc = (mean > 65535) ? 65535 : mean;
        l  = longint'(-nat_log(32'(65536 - tc)));
        d  = (diff_r == 0) ? 1 : 64'(diff_r);
        if (mode_r == ModeTrans2) d = d << 1;
        o = (l << 14) / d;
        if (o > 64'(Sat32)) o = 64'(Sat32);
      end else if (mode_r == ModeSquare) begin
        o = (mean * mean) >> 16;
        if (o > 64'(Sat32)) o = 64'(Sat32);
      end else begin
        o = mean;
      end
    end
    res.depth = o[31:0];
    wsum = 0; wtsum = 0; logsum = 0; nzwsum = 0; npts = 0; nnz = 0;
    return 1'b1;
  endfunction

  // wait until every expected row result has come back
  task automatic drain_rows();
    while (depth_q.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic idx, input logic [15:0] val);
    s_tvalid <= 1'b0;
    drain_rows();
    repeat (300) @(posedge clk);   // a non-last point may still be in the log chain
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegMode) mode_r = val[2:0];
    else diff_r = val;
  endtask

  // offer one point and wait for it to be taken; predict on acceptance
  task automatic send_point(input logic [31:0] metric, input logic [31:0] weight,
                            input bit last, input bit typed, input row_result_t typed_res);
    row_result_t res;
    s_tvalid <= 1'b1;
    s_tdata  <= {weight, metric};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (average_point(metric, weight, last, res)) depth_q.push_back(typed ? typed_res : res);
    // sender idles now and then
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    row_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (depth_q.size() == 0) begin
        $display("%0t: unexpected row result depth=%h zero_weight=%b",
                 $realtime, m_tdata, m_tuser);
        errors++;
      end else begin
        exp_res = depth_q.pop_front();
        if (m_tdata !== exp_res.depth) begin
          $display("%0t: optical_depth expected %h actual %h",
                   $realtime, exp_res.depth, m_tdata);
          errors++;
        end
        if (m_tuser !== exp_res.zero_wt) begin
          $display("%0t: zero_weight expected %b actual %b",
                   $realtime, exp_res.zero_wt, m_tuser);
          errors++;
        end
      end
    end
  end

  point_row_t  tab[$];
  row_result_t none_res;

  // helpers for building the table
  function automatic void add_pt(input logic [31:0] metric, input logic [31:0] weight,
                                 input bit last);
    point_row_t r;
    r = '{default: '0};
    r.metric = metric;
    r.weight = weight;
    r.last   = last;
    tab.push_back(r);
  endfunction

  function automatic void add_typed(input logic [31:0] metric, input logic [31:0] weight,
                                    input logic [31:0] depth, input logic zw);
    add_pt(metric, weight, 1'b1);
    tab[$].typed   = 1'b1;
    tab[$].depth   = depth;
    tab[$].zero_wt = zw;
  endfunction

  function automatic void add_wr(input logic idx, input logic [15:0] val);
    point_row_t r;
    r = '{default: '0};
    r.wr     = 1'b1;
    r.wr_idx = idx;
    r.wr_val = val;
    tab.push_back(r);
  endfunction

  initial begin
    row_result_t tr;
    int          sent, rows, len;
    logic [31:0] mv, wv;

    errors    = 0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    none_res  = '{depth: '0, zero_wt: 1'b0};
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = RegMode;
    cfg_data  = '0;
    mode_r    = ModeLinear;
    diff_r    = DiffReset;
    wsum = 0; wtsum = 0; logsum = 0; nzwsum = 0; npts = 0; nnz = 0;

    // directed table: linear after reset, extremes, every mode, special cases
    add_typed(32'h0005_0000, 32'h0001_0000, 32'h0005_0000, 1'b0);
    add_typed(32'h1234_5678, 32'h0, 32'h0, 1'b1);            // zero weight sum
    add_pt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_pt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_typed(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_wr(RegMode, 16'(ModeTrans));
    add_pt(32'h0000_8000, 32'h0001_0000, 1'b1);
    add_pt(32'h0002_0000, 32'h0000_0001, 1'b1);              // mean clamped below one
    add_wr(RegDiff, 16'h0000);                               // zero diffusivity
    add_pt(32'h0000_C000, 32'h0003_0000, 1'b1);
    add_wr(RegDiff, 16'hFFFF);
    add_pt(32'h0000_4000, 32'h0000_1000, 1'b1);
    add_wr(RegMode, 16'(ModeTrans2));
    add_pt(32'h0000_F000, 32'h0001_0000, 1'b1);
    add_wr(RegMode, 16'(ModeSquare));
    add_typed(32'hFFFF_FFFF, 32'h1, Sat32, 1'b0);            // square saturates
    add_wr(RegMode, 16'(ModeLog));
    add_typed(32'h0, 32'h5, 32'h0, 1'b0);                    // no nonzero metric
    add_typed(32'h0001_0000, 32'h0, 32'h0, 1'b1);            // nonzero weight sum zero
    add_pt(32'h0003_0000, 32'h0001_0000, 1'b0);
    add_pt(32'h0, 32'h0001_0000, 1'b1);
    add_wr(RegMode, 16'd7);                                  // unknown mode acts as linear
    add_typed(32'h0003_0000, 32'h7, 32'h0003_0000, 1'b0);
    add_pt(32'h0002_0000, 32'h1, 1'b0);
    add_wr(RegMode, 16'(ModeSquare));                        // mode changed mid-row
    add_pt(32'h0002_0000, 32'h1, 1'b1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (tab[i]) begin
      if (tab[i].wr) write_reg(tab[i].wr_idx, tab[i].wr_val);
      else begin
        tr = '{depth: tab[i].depth, zero_wt: tab[i].zero_wt};
        send_point(tab[i].metric, tab[i].weight, tab[i].last, tab[i].typed, tr);
      end
    end

    // random rows
    sent = 0;
    rows = 0;
    while (sent < 850) begin
      if (rows % 6 == 0) begin
        write_reg(RegMode, 16'($urandom_range(0, 7)));
        case ($urandom_range(0, 3))
          0:       write_reg(RegDiff, 16'($urandom_range(0, 1)));
          1:       write_reg(RegDiff, 16'hFFFF);
          default: write_reg(RegDiff, 16'($urandom));
        endcase
      end
      // receiver holds off while the sender keeps offering points
      if (rows == 20) hold_req = 1'b1;
      // sender pauses until every row result is back
      if (rows == 40) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        drain_rows();
      end
      if (sent > 750) quiet = 1'b1;
      len = (rows == 30) ? 530 : ($urandom_range(0, 9) == 0 ? $urandom_range(9, 40)
                                                             : $urandom_range(1, 6));
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0:       mv = 32'h0;
          1:       mv = 32'hFFFF_FFFF;
          2:       mv = 32'($urandom_range(0, 32'h0000_FFFF));
          3, 4:    mv = 32'($urandom_range(0, 32'h000F_FFFF));
          default: mv = $urandom;
        endcase
        case ($urandom_range(0, 7))
          0:       wv = 32'h0;
          1:       wv = 32'hFFFF_FFFF;
          2, 3:    wv = 32'($urandom_range(0, 32'h0003_FFFF));
          default: wv = $urandom;
        endcase
        send_point(mv, wv, k == len - 1, 1'b0, none_res);
        sent++;
      end
      rows++;
    end

    s_tvalid <= 1'b0;
    drain_rows();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("weighted_optical_depth_average_top: match");
    else $display("weighted_optical_depth_average_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
